// ===== src/pkd_pkg.sv =====
// Shared types and constants for the packed raster decoder.
`timescale 1ns / 1ps
`default_nettype none
package pkd_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int ROW_W = 64;

  // Special nybble codes of the packed format.
  localparam logic [3:0] NYB_REPEAT     = 4'd14;
  localparam logic [3:0] NYB_REPEAT_ONE = 4'd15;
  localparam logic [3:0] NYB_RAW_MODE   = 4'd14;
  localparam logic [4:0] ZERO_LIMIT     = 5'd16;
  localparam logic [6:0] REPEAT_SAT     = 7'd127;

  // Configuration register indexes.
  localparam logic [1:0] REG_DYN_F        = 2'd0;
  localparam logic [1:0] REG_START_BLACK  = 2'd1;
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

  // Token phases.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_TWO   = 2'd1;
  localparam logic [1:0] PH_ZEROS = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RAW,
    ST_RUN,
    ST_REP,
    ST_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TOKEN,
    CMD_RAW,
    CMD_RUN,
    CMD_RUN_END,
    CMD_REP,
    CMD_REP_END,
    CMD_FLUSH
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic raw_mode;
    logic token_run;
    logic raw_emit;
    logic raw_last;
    logic run_active;
    logic run_emit;
    logic rep_follow;
    logic rep_active;
    logic slot_ok;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] bits;
    logic [5:0]       row_number;
    logic             image_done;
  } result_t;

endpackage
`default_nettype wire

// ===== src/pkd_ctrl.sv =====
// Sequencing state machine of the packed raster decoder.
`timescale 1ns / 1ps
`default_nettype none
module pkd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pkd_pkg::dp_status_t status,
  output pkd_pkg::cmd_t       cmd
);
  import pkd_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.stopped) begin
          state_next = ST_FLUSH;
        end else if (status.raw_mode) begin
          cmd        = CMD_RAW;
          state_next = ST_RAW;
        end else begin
          cmd        = CMD_TOKEN;
          state_next = status.token_run ? ST_RUN : ST_FLUSH;
        end
      end
      ST_RAW: begin
        if (!status.raw_emit || status.slot_ok) begin
          cmd = CMD_RAW;
          if (status.raw_last) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_RUN: begin
        if (!status.run_active) begin
          cmd        = CMD_RUN_END;
          state_next = ST_FLUSH;
        end else if (!status.run_emit || status.slot_ok) begin
          cmd = CMD_RUN;
          if (status.rep_follow) begin
            state_next = ST_REP;
          end
        end
      end
      ST_REP: begin
        if (!status.rep_active) begin
          cmd        = CMD_REP_END;
          state_next = ST_RUN;
        end else if (status.slot_ok) begin
          cmd = CMD_REP;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd        = CMD_FLUSH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/pkd_datapath.sv =====
// Decoder state, token and run arithmetic, row buffer and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pkd_datapath #(
  parameter int MAX_WIDTH  = pkd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pkd_pkg::DEF_MAX_HEIGHT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire  [1:0]           cfg_index,
  input  wire  [6:0]           cfg_data,
  input  wire  [3:0]           in_nybble,
  input  wire                  in_new_glyph,
  input  pkd_pkg::cmd_t        cmd,
  output pkd_pkg::dp_status_t  status,
  input  wire                  out_ready,
  output logic                 out_valid,
  output pkd_pkg::result_t     out_res,
  output logic                 out_last
);
  import pkd_pkg::*;

  localparam logic [6:0] W_MAX = 7'(MAX_WIDTH);
  localparam logic [6:0] H_MAX = 7'(MAX_HEIGHT);
  localparam logic [ROW_W-1:0] ONES = {ROW_W{1'b1}};
  localparam logic [ROW_W-1:0] MSB  = {1'b1, {(ROW_W-1){1'b0}}};

  // Configuration registers.
  logic [3:0] dyn_f;
  logic       start_black;
  logic [6:0] glyph_width;
  logic [6:0] glyph_height;

  // Decoder state.
  logic [3:0]       nyb;
  logic [1:0]       bit_idx;
  logic [1:0]       phase;
  logic [4:0]       zeros_seen;
  logic [4:0]       nybbles_left;
  logic [3:0]       first_digit;
  logic [31:0]      acc;
  logic             repeat_pending;
  logic [6:0]       repeat_rows;
  logic [6:0]       rep_left;
  logic             colour;
  logic [6:0]       column;
  logic [6:0]       row;
  logic [ROW_W-1:0] row_buffer;
  logic             halted;
  logic [31:0]      run_left;

  // Result staging: a pending result waits until it is known whether it is the last.
  logic    pend_valid;
  result_t pend;

  logic [6:0] w_eff, h_eff;
  always_comb begin
    w_eff = (glyph_width == 7'd0) ? 7'd1 : ((glyph_width > W_MAX) ? W_MAX : glyph_width);
    h_eff = (glyph_height == 7'd0) ? 7'd1 : ((glyph_height > H_MAX) ? H_MAX : glyph_height);
  end

  // Token decoding for one packed nybble.
  logic        tk_fin, tk_err;
  logic [31:0] tk_num;
  logic [31:0] acc_new;
  logic [4:0]  nl_new;
  logic [33:0] num_wide;
  logic [7:0]  d15;
  always_comb begin
    tk_fin  = 1'b0;
    tk_err  = 1'b0;
    tk_num  = 32'd0;
    acc_new = (acc > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {acc[27:0], nyb};
    nl_new  = (nybbles_left != 5'd0) ? nybbles_left - 5'd1 : 5'd0;
    d15     = {dyn_f, 4'b0} - {4'b0, dyn_f};
    num_wide = {2'b0, acc_new} + 34'd193 - {26'b0, d15};
    case (phase)
      PH_START: begin
        if (nyb != NYB_REPEAT && nyb != NYB_REPEAT_ONE && nyb != 4'd0 && nyb <= dyn_f) begin
          tk_fin = 1'b1;
          tk_num = {28'b0, nyb};
        end
      end
      PH_TWO: begin
        // Full 32-bit arithmetic, so a dyn_f raised within the token wraps as expected.
        tk_fin = 1'b1;
        tk_num = ((32'(first_digit) - 32'(dyn_f) - 32'd1) << 4)
               + 32'(nyb) + 32'(dyn_f) + 32'd1;
      end
      PH_ZEROS: begin
        tk_err = (nyb == 4'd0) && (zeros_seen + 5'd1 > ZERO_LIMIT);
      end
      PH_DIGIT: begin
        if (nl_new == 5'd0) begin
          tk_fin = 1'b1;
          tk_num = (num_wide[33:32] != 2'b0) ? 32'hFFFF_FFFF : num_wide[31:0];
        end
      end
      default: begin
        tk_fin = 1'b0;
      end
    endcase
  end

  // Run step: fill up to the end of the row by mask.
  logic [6:0]       room, run_n, col_sum;
  logic [ROW_W-1:0] run_mask, run_row;
  always_comb begin
    room     = w_eff - column;
    run_n    = (run_left < {25'b0, room}) ? run_left[6:0] : room;
    col_sum  = column + run_n;
    run_mask = colour ? ((ONES >> column) & ~(ONES >> col_sum)) : '0;
    run_row  = row_buffer | run_mask;
  end

  // Raw step: one pixel.
  logic [ROW_W-1:0] raw_row;
  logic [6:0]       raw_col;
  always_comb begin
    raw_row = nyb[bit_idx] ? (row_buffer | (MSB >> column)) : row_buffer;
    raw_col = column + 7'd1;
  end

  // Status to the controller.
  logic out_free, emit;
  result_t emit_res;
  assign out_free = !out_valid || out_ready;
  always_comb begin
    status.stopped    = halted || (row >= h_eff);
    status.raw_mode   = (dyn_f >= NYB_RAW_MODE);
    status.token_run  = tk_fin && !repeat_pending;
    status.raw_emit   = (row < h_eff) && (raw_col >= w_eff);
    status.raw_last   = (bit_idx == 2'd0);
    status.run_active = (run_left != 32'd0) && (row < h_eff);
    status.run_emit   = (col_sum >= w_eff);
    status.rep_follow = (col_sum >= w_eff) && (repeat_rows != 7'd0) && (row + 7'd1 < h_eff);
    status.rep_active = (rep_left != 7'd0) && (row < h_eff);
    status.slot_ok    = !pend_valid || out_free;
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  // Result produced in this cycle, if any.
  always_comb begin
    emit = 1'b0;
    emit_res.kind       = 1'b0;
    emit_res.bits       = row_buffer;
    emit_res.row_number = row[5:0];
    emit_res.image_done = (row + 7'd1 == h_eff);
    case (cmd)
      CMD_TOKEN: begin
        if (tk_err) begin
          emit = 1'b1;
          emit_res.kind       = 1'b1;
          emit_res.bits       = '0;
          emit_res.image_done = 1'b0;
        end
      end
      CMD_RAW: begin
        emit = status.raw_emit;
        emit_res.bits = raw_row;
      end
      CMD_RUN: begin
        emit = status.run_emit;
        emit_res.bits = run_row;
      end
      CMD_REP: begin
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dyn_f        <= 4'd0;
      start_black  <= 1'b0;
      glyph_width  <= 7'd64;
      glyph_height <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DYN_F:        dyn_f        <= cfg_data[3:0];
        REG_START_BLACK:  start_black  <= cfg_data[0];
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data;
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data;
        default:          dyn_f        <= dyn_f;
      endcase
    end
  end

  // Decoder state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      zeros_seen     <= 5'd0;
      nybbles_left   <= 5'd0;
      first_digit    <= 4'd0;
      acc            <= 32'd0;
      repeat_pending <= 1'b0;
      repeat_rows    <= 7'd0;
      rep_left       <= 7'd0;
      colour         <= 1'b0;
      column         <= 7'd0;
      row            <= 7'd0;
      row_buffer     <= '0;
      halted         <= 1'b0;
      run_left       <= 32'd0;
      bit_idx        <= 2'd3;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          bit_idx <= 2'd3;
          if (in_new_glyph) begin
            phase          <= PH_START;
            zeros_seen     <= 5'd0;
            nybbles_left   <= 5'd0;
            first_digit    <= 4'd0;
            acc            <= 32'd0;
            repeat_pending <= 1'b0;
            repeat_rows    <= 7'd0;
            colour         <= start_black;
            column         <= 7'd0;
            row            <= 7'd0;
            row_buffer     <= '0;
            halted         <= 1'b0;
          end
        end
        CMD_TOKEN: begin
          case (phase)
            PH_START: begin
              if (nyb == NYB_REPEAT) begin
                repeat_pending <= 1'b1;
              end else if (nyb == NYB_REPEAT_ONE) begin
                repeat_rows <= 7'd1;
              end else if (nyb == 4'd0) begin
                zeros_seen <= 5'd1;
                phase      <= PH_ZEROS;
              end else if (!tk_fin) begin
                first_digit <= nyb;
                phase       <= PH_TWO;
              end
            end
            PH_ZEROS: begin
              if (nyb == 4'd0) begin
                zeros_seen <= zeros_seen + 5'd1;
                if (tk_err) begin
                  halted <= 1'b1;
                  phase  <= PH_START;
                end
              end else begin
                acc          <= {28'b0, nyb};
                nybbles_left <= zeros_seen;
                phase        <= PH_DIGIT;
              end
            end
            PH_DIGIT: begin
              acc          <= acc_new;
              nybbles_left <= nl_new;
            end
            default: begin
              phase <= phase;
            end
          endcase
          if (tk_fin) begin
            phase <= PH_START;
            if (repeat_pending) begin
              repeat_rows    <= (tk_num > 32'(REPEAT_SAT)) ? REPEAT_SAT : tk_num[6:0];
              repeat_pending <= 1'b0;
            end else begin
              run_left <= tk_num;
            end
          end
        end
        CMD_RAW: begin
          bit_idx <= bit_idx - 2'd1;
          if (row < h_eff) begin
            if (raw_col >= w_eff) begin
              row        <= row + 7'd1;
              column     <= 7'd0;
              row_buffer <= '0;
            end else begin
              column     <= raw_col;
              row_buffer <= raw_row;
            end
          end
        end
        CMD_RUN: begin
          run_left <= run_left - {25'b0, run_n};
          if (status.run_emit) begin
            row         <= row + 7'd1;
            repeat_rows <= 7'd0;
            if (status.rep_follow) begin
              rep_left   <= repeat_rows;
              row_buffer <= run_row;
              column     <= col_sum;
            end else begin
              column     <= 7'd0;
              row_buffer <= '0;
            end
          end else begin
            column     <= col_sum;
            row_buffer <= run_row;
          end
        end
        CMD_RUN_END: begin
          colour <= ~colour;
        end
        CMD_REP: begin
          row      <= row + 7'd1;
          rep_left <= rep_left - 7'd1;
        end
        CMD_REP_END: begin
          rep_left   <= 7'd0;
          column     <= 7'd0;
          row_buffer <= '0;
        end
        default: begin
          halted <= halted;
        end
      endcase
    end
  end

  // Captured input nybble.
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      nyb <= in_nybble;
    end
  end

  // Pending and output result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (cmd == CMD_FLUSH) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend <= emit_res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (cmd == CMD_FLUSH) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

`ifndef SYNTH
  // A pending result only moves out into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (emit && pend_valid) |-> out_free)
    else $error("result overwrote an untaken output");

  // Flushing empties the pending stage and leaves a final result.
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_FLUSH) |=> (!pend_valid && out_valid && out_last))
    else $error("flush did not deliver the final result");

  // The column never runs past the widest row.
  a_column: assert property (@(posedge clk) disable iff (rst)
    column <= W_MAX)
    else $error("column beyond row width");
`endif

endmodule
`default_nettype wire

// ===== src/pk_packed_raster_decoder_unit.sv =====
// Top level of the PK-font packed raster decoder.
//
// Usage: nybbles arrive on the s_axis stream, one transaction each, with
// tuser set on the first nybble of a glyph to clear the decoder state.
// Each completed pixel row (or a bad packed number error) leaves on the
// m_axis stream; tlast marks the final result caused by one nybble.
// Configuration registers dyn_f, start_black, glyph_width, glyph_height
// are written through the cfg channel (index 0..3). The user must write
// them only while the block is idle; the block itself does not enforce it.
// Sequence: a nybble is loaded and decoded, then gives four raw pixels in
// raw mode, or for a run fills row segments, pausing while the output is
// not free; a repeat that follows a row re-emits it. Each row step emits at most one row.
// Every result waits in a pending register until the next row step or the
// flush at the end of the nybble shows whether more follow, and moves into
// the output register at that step. The next nybble is taken in the cycle
// after the final result has moved into the output register.
// A stalled receiver holds the output register and pauses row emission.
// Reset restores the register defaults and clears the decoder state except the captured nybble.
`timescale 1ns / 1ps
`default_nettype none
module pk_packed_raster_decoder_unit #(
  parameter int MAX_WIDTH  = pkd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pkd_pkg::DEF_MAX_HEIGHT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [6:0]  cfg_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [3:0] nybble, [7:4] zero
  input  wire         s_axis_tuser,   // [0] new_glyph
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] row_bits, [69:64] row_number,
                                      // [70] image_done, [71] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);
  import pkd_pkg::*;

  cmd_t       cmd;
  dp_status_t status;
  result_t    res;

  assign cfg_ready = 1'b1;

  pkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pkd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_nybble    (s_axis_tdata[3:0]),
    .in_new_glyph (s_axis_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_res      (res),
    .out_last     (m_axis_tlast)
  );

  // Output packing.
  assign m_axis_tdata = {1'b0, res.image_done, res.row_number, res.bits};
  assign m_axis_tuser = res.kind;

endmodule
`default_nettype wire
